@@ hdl/vrp_pkg.sv @@
// Shared types, widths and helpers for the vertex rotate/project pipeline.
// Used by the channel interfaces and by every vrp module; no dependencies.
package vrp_pkg;

   localparam int COORD_W    = 24;
   localparam int TRIG_W     = 16;
   localparam int OFFSET_W   = 16;
   localparam int FOCAL_W    = 10;
   localparam int CENTER_W   = 12;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_LSB = 2;
   localparam int SAT_W      = 64;

   localparam int DEF_COORD_FRAC_BITS = 8;
   localparam int DEF_TRIG_FRAC_BITS  = 14;

   localparam int COS_ROT_RESET     = 16384;
   localparam int OFFSET_Z_RESET    = 150;
   localparam int FOCAL_SCALE_RESET = 100;
   localparam int CENTER_X_RESET    = 160;
   localparam int CENTER_Y_RESET    = 100;

   typedef enum logic [CSR_ADDR_W-REG_IDX_LSB-1:0] {
      REG_COS_ROT     = 3'd0,
      REG_SIN_ROT     = 3'd1,
      REG_OFFSET_X    = 3'd2,
      REG_OFFSET_Y    = 3'd3,
      REG_OFFSET_Z    = 3'd4,
      REG_FOCAL_SCALE = 3'd5,
      REG_CENTER_X    = 3'd6,
      REG_CENTER_Y    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0]   cos_rot;
      logic signed [TRIG_W-1:0]   sin_rot;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic signed [OFFSET_W-1:0] offset_z;
      logic        [FOCAL_W-1:0]  focal_scale;
      logic        [CENTER_W-1:0] center_x;
      logic        [CENTER_W-1:0] center_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cos_rot:     TRIG_W'(COS_ROT_RESET),
      sin_rot:     '0,
      offset_x:    '0,
      offset_y:    '0,
      offset_z:    OFFSET_W'(OFFSET_Z_RESET),
      focal_scale: FOCAL_W'(FOCAL_SCALE_RESET),
      center_x:    CENTER_W'(CENTER_X_RESET),
      center_y:    CENTER_W'(CENTER_Y_RESET)
   };

   localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (COORD_W - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // width of a rotated and translated view coordinate
   function automatic int view_w(input int f, input int t);
      return imax(imax(COORD_W + TRIG_W + 1 - t, OFFSET_W + f), COORD_W) + 1;
   endfunction

   // width of the projection numerator v * focal * 2^f
   function automatic int num_w(input int f, input int t);
      return view_w(f, t) + FOCAL_W + 1 + f;
   endfunction

   // quotient bits kept exactly; anything larger saturates the screen value
   function automatic int quot_w(input int f);
      return imax(COORD_W, CENTER_W + f) + 2;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/vrp_if.sv @@
// Valid/ready channel interfaces for vertex items and screen result items.
// Depends on vrp_pkg for the field widths.
interface vrp_vertex_if;
   import vrp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] vert_x;
   logic signed [COORD_W-1:0] vert_y;
   logic signed [COORD_W-1:0] vert_z;

   modport source (output valid, vert_x, vert_y, vert_z, input ready);
   modport sink   (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface vrp_screen_if;
   import vrp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] screen_x;
   logic signed [COORD_W-1:0] screen_y;
   logic signed [COORD_W-1:0] depth;
   logic                      zero_depth;

   modport source (output valid, screen_x, screen_y, depth, zero_depth, input ready);
   modport sink   (input valid, screen_x, screen_y, depth, zero_depth, output ready);
endinterface

@@ hdl/vrp_csr.sv @@
// APB-style configuration registers: rotation, offsets, focal scale, centers.
// Depends on vrp_pkg for the register map and cfg_type.
module vrp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [vrp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [vrp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [vrp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output vrp_pkg::cfg_type                cfg
);
   import vrp_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:REG_IDX_LSB]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_COS_ROT:     cfg_in.cos_rot     = pwdata[TRIG_W-1:0];
            REG_SIN_ROT:     cfg_in.sin_rot     = pwdata[TRIG_W-1:0];
            REG_OFFSET_X:    cfg_in.offset_x    = pwdata[OFFSET_W-1:0];
            REG_OFFSET_Y:    cfg_in.offset_y    = pwdata[OFFSET_W-1:0];
            REG_OFFSET_Z:    cfg_in.offset_z    = pwdata[OFFSET_W-1:0];
            REG_FOCAL_SCALE: cfg_in.focal_scale = pwdata[FOCAL_W-1:0];
            REG_CENTER_X:    cfg_in.center_x    = pwdata[CENTER_W-1:0];
            REG_CENTER_Y:    cfg_in.center_y    = pwdata[CENTER_W-1:0];
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_COS_ROT:     prdata[TRIG_W-1:0]   = cfg_ff.cos_rot;
         REG_SIN_ROT:     prdata[TRIG_W-1:0]   = cfg_ff.sin_rot;
         REG_OFFSET_X:    prdata[OFFSET_W-1:0] = cfg_ff.offset_x;
         REG_OFFSET_Y:    prdata[OFFSET_W-1:0] = cfg_ff.offset_y;
         REG_OFFSET_Z:    prdata[OFFSET_W-1:0] = cfg_ff.offset_z;
         REG_FOCAL_SCALE: prdata[FOCAL_W-1:0]  = cfg_ff.focal_scale;
         REG_CENTER_X:    prdata[CENTER_W-1:0] = cfg_ff.center_x;
         REG_CENTER_Y:    prdata[CENTER_W-1:0] = cfg_ff.center_y;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

`ifndef ASSERT_OFF
   a_focal_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && idx == REG_FOCAL_SCALE |=> cfg_ff.focal_scale == $past(pwdata[FOCAL_W-1:0]))
      else $error("focal_scale write not taken");
   a_hold_no_write: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(cfg_ff))
      else $error("configuration changed without a write");
   a_focal_read: assert property (@(posedge clock) disable iff (reset)
      psel && idx == REG_FOCAL_SCALE |-> prdata[CSR_DATA_W-1:FOCAL_W] == '0)
      else $error("focal_scale read shows stray upper bits");
`endif

endmodule

@@ hdl/vrp_rotate.sv @@
// Y-axis rotation and view translation, two register stages:
// four products, then rounded sums plus offsets. Depends on vrp_pkg.
module vrp_rotate #(
   parameter int COORD_FRAC_BITS = vrp_pkg::DEF_COORD_FRAC_BITS,
   parameter int TRIG_FRAC_BITS  = vrp_pkg::DEF_TRIG_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  vrp_pkg::cfg_type                       cfg,
   input  logic                                   in_valid,
   input  logic signed [vrp_pkg::COORD_W-1:0]     vert_x,
   input  logic signed [vrp_pkg::COORD_W-1:0]     vert_y,
   input  logic signed [vrp_pkg::COORD_W-1:0]     vert_z,
   output logic                                   out_valid,
   output logic signed [vrp_pkg::view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0] view_x,
   output logic signed [vrp_pkg::view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0] view_y,
   output logic signed [vrp_pkg::view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0] view_z
);
   import vrp_pkg::*;

   localparam int PROD_W = COORD_W + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int VW     = view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS);
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);

   logic                      v1_ff, v2_ff;
   logic signed [PROD_W-1:0]  zc_ff, xs_ff, zs_ff, xc_ff;
   logic signed [PROD_W-1:0]  zc_in, xs_in, zs_in, xc_in;
   logic signed [COORD_W-1:0] y1_ff;
   logic signed [SUM_W-1:0]   sum_x, sum_z, rnd_x, rnd_z;
   logic signed [VW-1:0]      vx_in, vy_in, vz_in;
   logic signed [VW-1:0]      vx_ff, vy_ff, vz_ff;

   always_comb begin
      zc_in = vert_z * cfg.cos_rot;
      xs_in = vert_x * cfg.sin_rot;
      zs_in = vert_z * cfg.sin_rot;
      xc_in = vert_x * cfg.cos_rot;
   end

   // round half up, then add the integer offsets scaled to coordinate format
   always_comb begin
      sum_x = SUM_W'(zc_ff) + SUM_W'(xs_ff);
      sum_z = SUM_W'(zs_ff) - SUM_W'(xc_ff);
      rnd_x = (sum_x + HALF) >>> TRIG_FRAC_BITS;
      rnd_z = (sum_z + HALF) >>> TRIG_FRAC_BITS;
      vx_in = VW'(rnd_x) + (VW'(cfg.offset_x) <<< COORD_FRAC_BITS);
      vy_in = VW'(y1_ff) + (VW'(cfg.offset_y) <<< COORD_FRAC_BITS);
      vz_in = VW'(rnd_z) + (VW'(cfg.offset_z) <<< COORD_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zc_ff <= zc_in;
         xs_ff <= xs_in;
         zs_ff <= zs_in;
         xc_ff <= xc_in;
         y1_ff <= vert_y;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
      end
   end

   assign out_valid = v2_ff;
   assign view_x    = vx_ff;
   assign view_y    = vy_ff;
   assign view_z    = vz_ff;

endmodule

@@ hdl/vrp_divide.sv @@
// Pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage with an overflow stage on top. Depends on vrp_pkg.
module vrp_divide #(
   parameter int COORD_FRAC_BITS = vrp_pkg::DEF_COORD_FRAC_BITS,
   parameter int TRIG_FRAC_BITS  = vrp_pkg::DEF_TRIG_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic signed [vrp_pkg::num_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0]  num_a,
   input  logic signed [vrp_pkg::num_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0]  num_b,
   input  logic signed [vrp_pkg::view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0] den,
   output logic out_valid,
   output logic signed [vrp_pkg::quot_w(COORD_FRAC_BITS)+1:0]                quot_a,
   output logic signed [vrp_pkg::quot_w(COORD_FRAC_BITS)+1:0]                quot_b,
   output logic signed [vrp_pkg::view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS)-1:0] den_out
);
   import vrp_pkg::*;

   localparam int VW  = view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS);
   localparam int NW  = num_w(COORD_FRAC_BITS, TRIG_FRAC_BITS);
   localparam int QB  = quot_w(COORD_FRAC_BITS);
   localparam int QOW = QB + 2;
   localparam int CW  = imax(NW, VW + QB) + 1;
   localparam int NST = QB + 1;

   logic                 val_ff    [0:NST];
   logic [CW-1:0]        rem_a_ff  [0:NST];
   logic [CW-1:0]        rem_b_ff  [0:NST];
   logic [QB-1:0]        quot_a_ff [0:NST];
   logic [QB-1:0]        quot_b_ff [0:NST];
   logic                 ovf_a_ff  [0:NST];
   logic                 ovf_b_ff  [0:NST];
   logic                 sign_a_ff [0:NST];
   logic                 sign_b_ff [0:NST];
   logic [VW-1:0]        dmag_ff   [0:NST];
   logic signed [VW-1:0] den_ff    [0:NST];

   logic [NW-1:0]         mag_a, mag_b;
   logic [VW-1:0]         mag_d;
   logic signed [QOW-1:0] qa_mag, qb_mag, qa_in, qb_in;
   logic signed [QOW-1:0] qa_ff, qb_ff;
   logic signed [VW-1:0]  dout_ff;
   logic                  vout_ff;

   // magnitudes and result signs; the divide runs on unsigned values
   always_comb begin
      mag_a = num_a[NW-1] ? -num_a : num_a;
      mag_b = num_b[NW-1] ? -num_b : num_b;
      mag_d = den[VW-1] ? -den : den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (adv) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_a_ff[0]  <= CW'(mag_a);
         rem_b_ff[0]  <= CW'(mag_b);
         quot_a_ff[0] <= '0;
         quot_b_ff[0] <= '0;
         ovf_a_ff[0]  <= 1'b0;
         ovf_b_ff[0]  <= 1'b0;
         sign_a_ff[0] <= num_a[NW-1] ^ den[VW-1];
         sign_b_ff[0] <= num_b[NW-1] ^ den[VW-1];
         dmag_ff[0]   <= mag_d;
         den_ff[0]    <= den;
      end
   end

   for (genvar j = 1; j <= NST; j++) begin : g_iter
      localparam int K = NST - j;

      logic [CW-1:0] dsh;
      logic          ge_a, ge_b;
      logic [CW-1:0] rem_a_in, rem_b_in;
      logic [QB-1:0] quot_a_in, quot_b_in;
      logic          ovf_a_in, ovf_b_in;

      always_comb begin
         dsh      = CW'(dmag_ff[j-1]) << K;
         ge_a     = rem_a_ff[j-1] >= dsh;
         ge_b     = rem_b_ff[j-1] >= dsh;
         rem_a_in = ge_a ? rem_a_ff[j-1] - dsh : rem_a_ff[j-1];
         rem_b_in = ge_b ? rem_b_ff[j-1] - dsh : rem_b_ff[j-1];
      end

      if (K == QB) begin : g_ovf
         // quotient does not fit in QB bits: the screen value saturates anyway
         always_comb begin
            quot_a_in = quot_a_ff[j-1];
            quot_b_in = quot_b_ff[j-1];
            ovf_a_in  = ge_a;
            ovf_b_in  = ge_b;
         end
      end else begin : g_bit
         always_comb begin
            quot_a_in    = quot_a_ff[j-1];
            quot_b_in    = quot_b_ff[j-1];
            quot_a_in[K] = ge_a;
            quot_b_in[K] = ge_b;
            ovf_a_in     = ovf_a_ff[j-1];
            ovf_b_in     = ovf_b_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[j] <= 1'b0;
         end else if (adv) begin
            val_ff[j] <= val_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_a_ff[j]  <= rem_a_in;
            rem_b_ff[j]  <= rem_b_in;
            quot_a_ff[j] <= quot_a_in;
            quot_b_ff[j] <= quot_b_in;
            ovf_a_ff[j]  <= ovf_a_in;
            ovf_b_ff[j]  <= ovf_b_in;
            sign_a_ff[j] <= sign_a_ff[j-1];
            sign_b_ff[j] <= sign_b_ff[j-1];
            dmag_ff[j]   <= dmag_ff[j-1];
            den_ff[j]    <= den_ff[j-1];
         end
      end
   end

   // apply sign, truncating toward zero
   always_comb begin
      qa_mag = ovf_a_ff[NST] ? (QOW'(1) <<< QB) : QOW'(quot_a_ff[NST]);
      qb_mag = ovf_b_ff[NST] ? (QOW'(1) <<< QB) : QOW'(quot_b_ff[NST]);
      qa_in  = sign_a_ff[NST] ? -qa_mag : qa_mag;
      qb_in  = sign_b_ff[NST] ? -qb_mag : qb_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (adv) begin
         vout_ff <= val_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qa_ff   <= qa_in;
         qb_ff   <= qb_in;
         dout_ff <= den_ff[NST];
      end
   end

   assign out_valid = vout_ff;
   assign quot_a    = qa_ff;
   assign quot_b    = qb_ff;
   assign den_out   = dout_ff;

`ifndef ASSERT_OFF
   a_rem_a_final: assert property (@(posedge clock) disable iff (reset)
      val_ff[NST] && !ovf_a_ff[NST] && dmag_ff[NST] != '0
      |-> rem_a_ff[NST] < CW'(dmag_ff[NST]))
      else $error("x remainder not below divisor after last step");
   a_rem_b_final: assert property (@(posedge clock) disable iff (reset)
      val_ff[NST] && !ovf_b_ff[NST] && dmag_ff[NST] != '0
      |-> rem_b_ff[NST] < CW'(dmag_ff[NST]))
      else $error("y remainder not below divisor after last step");
   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      val_ff[1] && !ovf_a_ff[1] |-> rem_a_ff[1] < (CW'(dmag_ff[1]) << QB))
      else $error("overflow stage passed an out-of-range numerator");
`endif

endmodule

@@ hdl/vertex_rotate_project.sv @@
// Top level: input skid stage, rotation, projection scale, divider, output stage.
// Depends on vrp_pkg, vrp_if, vrp_csr, vrp_rotate and vrp_divide.
//
//   port group   direction  handshake            payload
//   req_vertex   in         valid/ready          vert_x, vert_y, vert_z
//   rsp_screen   out        valid/ready          screen_x, screen_y, depth, zero_depth
//   p* (APB)     in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One vertex per cycle unless a held result stalls the pipeline; the divider resolves one
//   quotient bit per stage, with QB = max(24, 12 + COORD_FRAC_BITS) + 2 quotient bits.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A held result stalls the whole pipeline; the skid stage still takes one more item.
module vertex_rotate_project #(
   parameter int COORD_FRAC_BITS = vrp_pkg::DEF_COORD_FRAC_BITS,
   parameter int TRIG_FRAC_BITS  = vrp_pkg::DEF_TRIG_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   vrp_vertex_if.sink                     req_vertex,
   vrp_screen_if.source                   rsp_screen,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vrp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [vrp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [vrp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import vrp_pkg::*;

   localparam int VW  = view_w(COORD_FRAC_BITS, TRIG_FRAC_BITS);
   localparam int NW  = num_w(COORD_FRAC_BITS, TRIG_FRAC_BITS);
   localparam int QB  = quot_w(COORD_FRAC_BITS);
   localparam int QOW = QB + 2;
   localparam int SW  = QB + 3;
   localparam int MW  = VW + FOCAL_W + 1;

   cfg_type cfg;
   logic    adv;

   logic                      skid_v_ff, skid_v_in;
   logic signed [COORD_W-1:0] skid_x_ff, skid_y_ff, skid_z_ff;
   logic signed [COORD_W-1:0] skid_x_in, skid_y_in, skid_z_in;
   logic                      pipe_valid;
   logic signed [COORD_W-1:0] pipe_x, pipe_y, pipe_z;

   logic                 rot_valid;
   logic signed [VW-1:0] view_x, view_y, view_z;

   logic signed [FOCAL_W:0] focal_s;
   logic signed [MW-1:0]    sc_x, sc_y;
   logic signed [NW-1:0]    nx_in, ny_in, nx_ff, ny_ff;
   logic signed [VW-1:0]    vz3_ff;
   logic                    v3_ff;

   logic                  div_valid;
   logic signed [QOW-1:0] quot_x, quot_y;
   logic signed [VW-1:0]  div_z;

   logic signed [SW-1:0]      cx_s, cy_s, sum_x, sum_y;
   logic                      zero_in;
   logic signed [COORD_W-1:0] out_x_in, out_y_in, out_d_in;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, out_d_ff;
   logic                      out_z_in, out_z_ff;
   logic                      out_v_ff;

   vrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // the whole pipeline moves unless a result is held at the output
   assign adv = !out_v_ff || rsp_screen.ready;

   assign req_vertex.ready = !skid_v_ff;

   always_comb begin
      pipe_valid = skid_v_ff | req_vertex.valid;
      pipe_x     = skid_v_ff ? skid_x_ff : req_vertex.vert_x;
      pipe_y     = skid_v_ff ? skid_y_ff : req_vertex.vert_y;
      pipe_z     = skid_v_ff ? skid_z_ff : req_vertex.vert_z;
      skid_x_in  = skid_v_ff ? skid_x_ff : req_vertex.vert_x;
      skid_y_in  = skid_v_ff ? skid_y_ff : req_vertex.vert_y;
      skid_z_in  = skid_v_ff ? skid_z_ff : req_vertex.vert_z;
      skid_v_in  = skid_v_ff;
      if (adv) begin
         skid_v_in = 1'b0;
      end else if (req_vertex.valid && !skid_v_ff) begin
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_x_ff <= skid_x_in;
      skid_y_ff <= skid_y_in;
      skid_z_ff <= skid_z_in;
   end

   vrp_rotate #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (pipe_valid),
      .vert_x    (pipe_x),
      .vert_y    (pipe_y),
      .vert_z    (pipe_z),
      .out_valid (rot_valid),
      .view_x    (view_x),
      .view_y    (view_y),
      .view_z    (view_z)
   );

   // projection numerators: v * focal * 2^F
   always_comb begin
      focal_s = signed'({1'b0, cfg.focal_scale});
      sc_x    = view_x * focal_s;
      sc_y    = view_y * focal_s;
      nx_in   = NW'(sc_x) <<< COORD_FRAC_BITS;
      ny_in   = NW'(sc_y) <<< COORD_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         vz3_ff <= view_z;
      end
   end

   vrp_divide #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .num_a     (nx_ff),
      .num_b     (ny_ff),
      .den       (vz3_ff),
      .out_valid (div_valid),
      .quot_a    (quot_x),
      .quot_b    (quot_y),
      .den_out   (div_z)
   );

   // add screen centers, saturate; zero depth forces the screen values and depth to 0
   always_comb begin
      cx_s    = SW'(cfg.center_x) << COORD_FRAC_BITS;
      cy_s    = SW'(cfg.center_y) << COORD_FRAC_BITS;
      sum_x   = SW'(quot_x) + cx_s;
      sum_y   = cy_s - SW'(quot_y);
      zero_in = (div_z == '0);
      if (zero_in) begin
         out_x_in = '0;
         out_y_in = '0;
         out_d_in = '0;
         out_z_in = 1'b1;
      end else begin
         out_x_in = sat_coord(SAT_W'(sum_x));
         out_y_in = sat_coord(SAT_W'(sum_y));
         out_d_in = sat_coord(SAT_W'(div_z));
         out_z_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_d_ff <= out_d_in;
         out_z_ff <= out_z_in;
      end
   end

   assign rsp_screen.valid      = out_v_ff;
   assign rsp_screen.screen_x   = out_x_ff;
   assign rsp_screen.screen_y   = out_y_ff;
   assign rsp_screen.depth      = out_d_ff;
   assign rsp_screen.zero_depth = out_z_ff;

`ifndef ASSERT_OFF
   a_zero_forces: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_z_ff |-> out_x_ff == '0 && out_y_ff == '0 && out_d_ff == '0)
      else $error("zero depth item carries nonzero coordinates");
   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_z_ff |-> out_d_ff != '0)
      else $error("nonzero depth flag with zero depth");
   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      req_vertex.valid && req_vertex.ready && !adv |=> skid_v_ff)
      else $error("item accepted during stall not held in skid stage");
`endif

endmodule
